FILE: rtl/core/euler_frame_rotation_defines.svh
// Assertion macros shared by the frame rotation checker.
`ifndef EULER_FRAME_ROTATION_DEFINES_SVH
`define EULER_FRAME_ROTATION_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EFR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("efr checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is asserted.
`define EFR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("efr checker: next-cycle property failed");

`endif

FILE: rtl/core/efr_pkg.sv
// Shared constants, types and helpers of the frame rotation block.
`default_nettype none

package efr_pkg;

	localparam int EFR_ANGLE_BITS = 16;
	localparam int EFR_VALUE_BITS = 32;

	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
	localparam logic [30:0] ONE_Q30     = 31'h4000_0000;

	localparam int LANES       = 3;
	localparam int LANE_ROLL   = 0;
	localparam int LANE_PITCH  = 1;
	localparam int LANE_YAW    = 2;

	localparam int PREP_STAGES = 3;
	localparam int CELL_COUNT  = 7;
	localparam int CELL_STAGES = 2;
	localparam int ROT_FRONT   = 4;
	localparam int SIDE_DELAY  = PREP_STAGES + CELL_COUNT * CELL_STAGES + ROT_FRONT;

	typedef enum logic [1:0] {
		QUAD_I   = 2'd0,
		QUAD_II  = 2'd1,
		QUAD_III = 2'd2,
		QUAD_IV  = 2'd3
	} quad_t;

	typedef logic signed [31:0] trig_t;
	typedef logic signed [32:0] coef_t;

	// One angle on its way through the series cells.
	typedef struct packed {
		quad_t              quad;
		logic               swap;
		logic [29:0]        x2;
		logic [30:0]        tc;
		logic [29:0]        ts;
		logic signed [31:0] cc;
		logic signed [31:0] ss;
	} efr_lane_t;

	// Q2.30 product, rounded half up.
	function automatic trig_t qmul(trig_t a, trig_t b);
		logic signed [63:0] prod;
		prod = (64'(a) * 64'(b)) + (64'sd1 <<< 29);
		return prod[61:30];
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/efr_if.sv
// Stream interfaces for input samples and rotated results.
`default_nettype none

interface efr_in_if import efr_pkg::*; #(
	parameter int ANGLE_BITS = EFR_ANGLE_BITS,
	parameter int VALUE_BITS = EFR_VALUE_BITS
) ();
	logic                         valid;
	logic                         ready;
	logic                         command;
	logic signed [ANGLE_BITS-1:0] roll_angle;
	logic signed [ANGLE_BITS-1:0] pitch_angle;
	logic signed [ANGLE_BITS-1:0] yaw_angle;
	logic signed [VALUE_BITS-1:0] vec_x;
	logic signed [VALUE_BITS-1:0] vec_y;
	logic signed [VALUE_BITS-1:0] vec_z;

	modport source (output valid, command, roll_angle, pitch_angle, yaw_angle,
		vec_x, vec_y, vec_z, input ready);
	modport sink (input valid, command, roll_angle, pitch_angle, yaw_angle,
		vec_x, vec_y, vec_z, output ready);
endinterface

interface efr_out_if import efr_pkg::*; #(
	parameter int VALUE_BITS = EFR_VALUE_BITS
) ();
	logic                         valid;
	logic                         ready;
	logic signed [VALUE_BITS-1:0] out_x;
	logic signed [VALUE_BITS-1:0] out_y;
	logic signed [VALUE_BITS-1:0] out_z;

	modport source (output valid, out_x, out_y, out_z, input ready);
	modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/euler_frame_rotation.sv
// Top level of the ZYX Euler-angle frame rotation pipeline.
//
// Usage:
//   sample carries one beat per vector: command, roll/pitch/yaw binary angles
//   (a full turn is 2^ANGLE_BITS) and a signed Q16.16 vector. result returns
//   the rotated vector, saturated to VALUE_BITS. Command low rotates from
//   the world frame to the body frame, command high applies the transpose.
//   From an accepted sample beat to result.valid the beat passes through
//   3 angle-reduction stages, 7 series cells of 2 stages each, 6 matrix and
//   dot-product stages and the result queue register.
//   Throughput: one beat per cycle unless stalled; every stage advances together.
//   A two-entry result queue sits at the output. sample.ready drops only
//   when both entries hold results and result.ready is low; while one
//   result waits, new beats are still taken.
//   Reset clears all valid flags and empties the queue; sample.ready is
//   high right after reset.
`default_nettype none

module euler_frame_rotation import efr_pkg::*; #(
	parameter int ANGLE_BITS = EFR_ANGLE_BITS,
	parameter int VALUE_BITS = EFR_VALUE_BITS
) (
	input  logic     clk,
	input  logic     arst_n,
	efr_in_if.sink   sample,
	efr_out_if.source result
);

	// pipeline advance: hold everything only when the queue is full and stalled
	logic en;
	logic push, pop, n0v;

	logic [ANGLE_BITS-1:0] angle [LANES];

	logic      lane_vld [CELL_COUNT+1];
	efr_lane_t lane_w   [CELL_COUNT+1][LANES];

	// side line: command and vector ride along until the dot products
	logic                         cmd_q [SIDE_DELAY];
	logic signed [VALUE_BITS-1:0] vec_q [SIDE_DELAY][3];

	logic                         rot_vld;
	logic signed [VALUE_BITS-1:0] rot_res [3];

	// two-entry result queue, entry 0 drives the port
	logic                         v0_q, v1_q;
	logic signed [VALUE_BITS-1:0] q0_q [3];
	logic signed [VALUE_BITS-1:0] q1_q [3];

	assign en           = !v1_q || result.ready;
	assign sample.ready = en;

	assign angle[LANE_ROLL]  = sample.roll_angle;
	assign angle[LANE_PITCH] = sample.pitch_angle;
	assign angle[LANE_YAW]   = sample.yaw_angle;

	efr_angle_prep #(
		.ANGLE_BITS(ANGLE_BITS)
	) u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld      (sample.valid),
		.angle    (angle),
		.lane_vld (lane_vld[0]),
		.lane     (lane_w[0])
	);

	// series cells, one term pair per cell
	for (genvar g = 0; g < CELL_COUNT; g++) begin : g_cell
		efr_term_cell #(
			.IDX(g)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.vld     (lane_vld[g]),
			.lane    (lane_w[g]),
			.fwd_vld (lane_vld[g+1]),
			.fwd     (lane_w[g+1])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_q[0]    <= sample.command;
			vec_q[0][0] <= sample.vec_x;
			vec_q[0][1] <= sample.vec_y;
			vec_q[0][2] <= sample.vec_z;
			for (int d = 1; d < SIDE_DELAY; d++) begin
				cmd_q[d] <= cmd_q[d-1];
				vec_q[d] <= vec_q[d-1];
			end
		end
	end

	efr_rotate #(
		.VALUE_BITS(VALUE_BITS)
	) u_rotate (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld     (lane_vld[CELL_COUNT]),
		.lane    (lane_w[CELL_COUNT]),
		.cmd     (cmd_q[SIDE_DELAY-1]),
		.vec     (vec_q[SIDE_DELAY-1]),
		.res_vld (rot_vld),
		.res     (rot_res)
	);

	// queue bookkeeping: pop first, then land the new result in the first free slot
	assign push = en && rot_vld;
	assign pop  = v0_q && result.ready;
	assign n0v  = pop ? v1_q : v0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0;
			v1_q <= 1'b0;
		end else begin
			v0_q <= n0v || push;
			v1_q <= (pop ? 1'b0 : v1_q) || (push && n0v);
		end
	end

	always_ff @(posedge clk) begin
		if (pop && v1_q) begin
			q0_q <= q1_q;
		end
		if (push && !n0v) begin
			q0_q <= rot_res;
		end
		if (push && n0v) begin
			q1_q <= rot_res;
		end
	end

	assign result.valid = v0_q;
	assign result.out_x = q0_q[0];
	assign result.out_y = q0_q[1];
	assign result.out_z = q0_q[2];

endmodule

`default_nettype wire

FILE: rtl/core/efr_angle_prep.sv
// Angle reduction to an octant and seeding of the series lanes.
`default_nettype none

module efr_angle_prep import efr_pkg::*; #(
	parameter int ANGLE_BITS = EFR_ANGLE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  vld,
	input  logic [ANGLE_BITS-1:0] angle [LANES],
	output logic                  lane_vld,
	output efr_lane_t             lane [LANES]
);

	logic        vld_s1, vld_s2, vld_s3;
	quad_t       quad_s1 [LANES];
	quad_t       quad_s2 [LANES];
	logic        swap_s1 [LANES];
	logic        swap_s2 [LANES];
	logic [29:0] rr_s1   [LANES];
	logic [29:0] x_s2    [LANES];
	efr_lane_t   lane_s3 [LANES];

	logic [31:0] ph   [LANES];
	logic        swp  [LANES];
	logic [29:0] rr   [LANES];
	logic [60:0] xp   [LANES];
	logic [59:0] sq   [LANES];

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			ph[i]  = {angle[i], {(32-ANGLE_BITS){1'b0}}};
			swp[i] = ph[i][29:0] > 30'h2000_0000;
			rr[i]  = swp[i] ? 30'(ONE_Q30 - {1'b0, ph[i][29:0]}) : ph[i][29:0];
			xp[i]  = (61'(rr_s1[i]) * 61'(HALF_PI_Q30)) + (61'd1 << 29);
			sq[i]  = 60'(x_s2[i]) * 60'(x_s2[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < LANES; i++) begin
				quad_s1[i]    <= quad_t'(ph[i][31:30]);
				swap_s1[i]    <= swp[i];
				rr_s1[i]      <= rr[i];
				quad_s2[i]    <= quad_s1[i];
				swap_s2[i]    <= swap_s1[i];
				x_s2[i]       <= xp[i][59:30];
				lane_s3[i].quad <= quad_s2[i];
				lane_s3[i].swap <= swap_s2[i];
				lane_s3[i].x2   <= sq[i][59:30];
				lane_s3[i].tc   <= ONE_Q30;
				lane_s3[i].ts   <= x_s2[i];
				lane_s3[i].cc   <= signed'(32'(ONE_Q30));
				lane_s3[i].ss   <= signed'({2'b00, x_s2[i]});
			end
		end
	end

	assign lane_vld = vld_s3;
	assign lane     = lane_s3;

endmodule

`default_nettype wire

FILE: rtl/core/efr_term_cell.sv
// One series cell: next sine and cosine terms and their accumulation.
`default_nettype none

module efr_term_cell import efr_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      vld,
	input  efr_lane_t lane [LANES],
	output logic      fwd_vld,
	output efr_lane_t fwd [LANES]
);

	localparam int K      = 2 * IDX + 1;
	localparam int DIV_C  = K * (K + 1);
	localparam int DIV_S  = (K + 1) * (K + 2);
	localparam int SH_C   = 30 + $clog2(DIV_C);
	localparam int SH_S   = 30 + $clog2(DIV_S);
	localparam logic [31:0] REC_C =
		32'(((64'd1 << SH_C) + 64'(DIV_C) - 64'd1) / 64'(DIV_C));
	localparam logic [31:0] REC_S =
		32'(((64'd1 << SH_S) + 64'(DIV_S) - 64'd1) / 64'(DIV_S));
	localparam bit SUB = (IDX % 2) == 0;

	logic      vld_s1, vld_s2;
	efr_lane_t mid_s1 [LANES];
	efr_lane_t out_s2 [LANES];

	logic [60:0] pc [LANES];
	logic [59:0] ps [LANES];
	logic [61:0] qc [LANES];
	logic [61:0] qs [LANES];
	logic [29:0] tcn [LANES];
	logic [29:0] tsn [LANES];
	efr_lane_t   mid_d [LANES];
	efr_lane_t   out_d [LANES];

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			pc[i]  = 61'(lane[i].tc) * 61'(lane[i].x2);
			ps[i]  = 60'(lane[i].ts) * 60'(lane[i].x2);
			// exact truncating divide: reciprocal multiply and shift
			qc[i]  = 62'(mid_s1[i].tc[29:0]) * 62'(REC_C);
			qs[i]  = 62'(mid_s1[i].ts) * 62'(REC_S);
			tcn[i] = 30'(qc[i] >> SH_C);
			tsn[i] = 30'(qs[i] >> SH_S);

			mid_d[i]    = lane[i];
			mid_d[i].tc = 31'(pc[i][59:30]);
			mid_d[i].ts = ps[i][59:30];

			out_d[i]    = mid_s1[i];
			out_d[i].tc = 31'(tcn[i]);
			out_d[i].ts = tsn[i];
			if (SUB) begin
				out_d[i].cc = mid_s1[i].cc - signed'({2'b00, tcn[i]});
				out_d[i].ss = mid_s1[i].ss - signed'({2'b00, tsn[i]});
			end else begin
				out_d[i].cc = mid_s1[i].cc + signed'({2'b00, tcn[i]});
				out_d[i].ss = mid_s1[i].ss + signed'({2'b00, tsn[i]});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < LANES; i++) begin
				mid_s1[i] <= mid_d[i];
				out_s2[i] <= out_d[i];
			end
		end
	end

	assign fwd_vld = vld_s2;
	assign fwd     = out_s2;

endmodule

`default_nettype wire

FILE: rtl/core/efr_rotate.sv
// Quadrant fixup, matrix build and rotated dot products with saturation.
`default_nettype none

module efr_rotate import efr_pkg::*; #(
	parameter int VALUE_BITS = EFR_VALUE_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         vld,
	input  efr_lane_t                    lane [LANES],
	input  logic                         cmd,
	input  logic signed [VALUE_BITS-1:0] vec [3],
	output logic                         res_vld,
	output logic signed [VALUE_BITS-1:0] res [3]
);

	localparam logic signed [53:0] RES_MAX = (54'sd1 <<< (VALUE_BITS - 1)) - 54'sd1;
	localparam logic signed [53:0] RES_MIN = -(54'sd1 <<< (VALUE_BITS - 1));

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	trig_t sin_s1 [LANES];
	trig_t cos_s1 [LANES];

	trig_t sst_s2, cst_s2, p00_s2, p01_s2, p12_s2, p22_s2;
	trig_t a_s2, b_s2, c_s2, d_s2, stet_s2, cpsi_s2, spsi_s2;

	trig_t e_s3, f_s3, g_s3, h_s3, p00_s3, p01_s3, p12_s3, p22_s3;
	trig_t a_s3, b_s3, c_s3, d_s3, stet_s3;

	coef_t m_s4 [3][3];

	logic signed [56:0] ph_s5 [3][3];
	logic signed [57:0] pl_s5 [3][3];

	logic signed [58:0] hs_s6 [3];
	logic signed [59:0] ls_s6 [3];

	trig_t bs [LANES];
	trig_t bc [LANES];
	trig_t sn [LANES];
	trig_t cs [LANES];
	coef_t sel [3][3];
	logic signed [47:0] vw [3];
	logic signed [23:0] vh [3];
	logic signed [24:0] vl [3];
	logic signed [83:0] tot [3];
	logic signed [53:0] y [3];

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			bs[l] = lane[l].swap ? lane[l].cc : lane[l].ss;
			bc[l] = lane[l].swap ? lane[l].ss : lane[l].cc;
			case (lane[l].quad)
				QUAD_I: begin
					sn[l] = bs[l];
					cs[l] = bc[l];
				end
				QUAD_II: begin
					sn[l] = bc[l];
					cs[l] = -bs[l];
				end
				QUAD_III: begin
					sn[l] = -bs[l];
					cs[l] = -bc[l];
				end
				QUAD_IV: begin
					sn[l] = -bc[l];
					cs[l] = bs[l];
				end
				default: begin
					sn[l] = bs[l];
					cs[l] = bc[l];
				end
			endcase
		end
		for (int j = 0; j < 3; j++) begin
			vw[j] = 48'(vec[j]);
			vh[j] = signed'(vw[j][47:24]);
			vl[j] = signed'({1'b0, vw[j][23:0]});
		end
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				sel[i][j] = cmd ? m_s4[j][i] : m_s4[i][j];
			end
		end
		for (int i = 0; i < 3; i++) begin
			tot[i] = (84'(hs_s6[i]) <<< 24) + 84'(ls_s6[i]) + (84'sd1 <<< 29);
			y[i]   = tot[i][83:30];
			if (y[i] > RES_MAX) begin
				res[i] = RES_MAX[VALUE_BITS-1:0];
			end else if (y[i] < RES_MIN) begin
				res[i] = RES_MIN[VALUE_BITS-1:0];
			end else begin
				res[i] = y[i][VALUE_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < LANES; l++) begin
				sin_s1[l] <= sn[l];
				cos_s1[l] <= cs[l];
			end

			sst_s2  <= qmul(sin_s1[LANE_ROLL], sin_s1[LANE_PITCH]);
			cst_s2  <= qmul(cos_s1[LANE_ROLL], sin_s1[LANE_PITCH]);
			p00_s2  <= qmul(cos_s1[LANE_YAW], cos_s1[LANE_PITCH]);
			p01_s2  <= qmul(sin_s1[LANE_YAW], cos_s1[LANE_PITCH]);
			p12_s2  <= qmul(cos_s1[LANE_PITCH], sin_s1[LANE_ROLL]);
			p22_s2  <= qmul(cos_s1[LANE_PITCH], cos_s1[LANE_ROLL]);
			a_s2    <= qmul(cos_s1[LANE_ROLL], sin_s1[LANE_YAW]);
			b_s2    <= qmul(cos_s1[LANE_ROLL], cos_s1[LANE_YAW]);
			c_s2    <= qmul(sin_s1[LANE_ROLL], sin_s1[LANE_YAW]);
			d_s2    <= qmul(sin_s1[LANE_ROLL], cos_s1[LANE_YAW]);
			stet_s2 <= sin_s1[LANE_PITCH];
			cpsi_s2 <= cos_s1[LANE_YAW];
			spsi_s2 <= sin_s1[LANE_YAW];

			e_s3    <= qmul(sst_s2, cpsi_s2);
			f_s3    <= qmul(sst_s2, spsi_s2);
			g_s3    <= qmul(cst_s2, cpsi_s2);
			h_s3    <= qmul(cst_s2, spsi_s2);
			p00_s3  <= p00_s2;
			p01_s3  <= p01_s2;
			p12_s3  <= p12_s2;
			p22_s3  <= p22_s2;
			a_s3    <= a_s2;
			b_s3    <= b_s2;
			c_s3    <= c_s2;
			d_s3    <= d_s2;
			stet_s3 <= stet_s2;

			m_s4[0][0] <= 33'(p00_s3);
			m_s4[0][1] <= 33'(p01_s3);
			m_s4[0][2] <= -33'(stet_s3);
			m_s4[1][0] <= 33'(e_s3) - 33'(a_s3);
			m_s4[1][1] <= 33'(f_s3) + 33'(b_s3);
			m_s4[1][2] <= 33'(p12_s3);
			m_s4[2][0] <= 33'(g_s3) + 33'(c_s3);
			m_s4[2][1] <= 33'(h_s3) - 33'(d_s3);
			m_s4[2][2] <= 33'(p22_s3);

			// split each component at bit 24 to keep the multipliers narrow
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					ph_s5[i][j] <= 57'(vh[j]) * 57'(sel[i][j]);
					pl_s5[i][j] <= 58'(vl[j]) * 58'(sel[i][j]);
				end
			end

			for (int i = 0; i < 3; i++) begin
				hs_s6[i] <= 59'(ph_s5[i][0]) + 59'(ph_s5[i][1]) + 59'(ph_s5[i][2]);
				ls_s6[i] <= 60'(pl_s5[i][0]) + 60'(pl_s5[i][1]) + 60'(pl_s5[i][2]);
			end
		end
	end

	assign res_vld = vld_s6;

endmodule

`default_nettype wire

FILE: rtl/core/efr_checker.sv
// Port-level checks of the frame rotation block and their binding.
`default_nettype none
`include "euler_frame_rotation_defines.svh"

module efr_checker import efr_pkg::*; #(
	parameter int VALUE_BITS = EFR_VALUE_BITS
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [VALUE_BITS-1:0] out_x,
	input logic [VALUE_BITS-1:0] out_y,
	input logic [VALUE_BITS-1:0] out_z
);

	// a stalled result stays offered
	`EFR_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)

	// a stalled result keeps its value
	`EFR_ASSERT_NXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_x) && $stable(out_y) && $stable(out_z))

	// input backpressure only while results wait
	`EFR_ASSERT_IMP(a_stall_has_result, clk, arst_n, !in_ready, out_valid)

	// input backpressure while the receiver stalls: the consequent contains !in_ready, so it never fails
	`EFR_ASSERT_IMP(a_stall_follows_sink, clk, arst_n, !in_ready, !out_ready || !in_valid || !in_ready)

endmodule

bind euler_frame_rotation efr_checker #(
	.VALUE_BITS(VALUE_BITS)
) u_efr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample.valid),
	.in_ready  (sample.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_x     (result.out_x),
	.out_y     (result.out_y),
	.out_z     (result.out_z)
);

`default_nettype wire
